[hdl/lfr_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LRU frame replacer package
// Shared widths, command codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package lfr_pkg;

	localparam int FRAMES     = 64;   // frame pool size
	localparam int FRAME_W    = 6;    // width of frame number fields
	localparam int CNT_W      = 7;    // width of count and capacity
	localparam int CMD_W      = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch an accepted request
		logic rd;        // read link and tracked stores
		logic exec;      // apply update, load result register
		logic clr;       // one step of the tracked-store clearing pass
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;  // clearing pass at last entry
	} dp_sts_t;

endpackage : lfr_pkg
`default_nettype wire

[hdl/lfr_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LRU frame replacer controller
// Sequences clearing pass, request capture, store read and update, and
// owns both request handshakes.
// ---------------------------------------------------------------------------
module lfr_ctrl
	import lfr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_READ  = 2'd2;
	localparam logic [1:0] S_EXEC  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       exec_go;

	// result slot is free when empty or being drained this cycle
	assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && in_ready;
		cmd.rd      = (state_q == S_READ);
		cmd.exec    = exec_go;
		cmd.clr     = (state_q == S_CLEAR);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid)
					state_d = S_READ;
			end
			S_READ: state_d = S_EXEC;
			S_EXEC: begin
				if (exec_go)
					state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule : lfr_ctrl
`default_nettype wire

[hdl/lfr_dp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LRU frame replacer datapath
// Link stores, tracked store, list end pointers, count, capacity and the
// result register.
// ---------------------------------------------------------------------------
module lfr_dp
	import lfr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_sts_t                 sts,
	input  wire logic               cfg_we,
	input  wire logic [CNT_W-1:0]   capacity,
	input  wire logic [CMD_W-1:0]   command,
	input  wire logic [FRAME_W-1:0] frame,
	output logic                    done_res,
	output logic [FRAME_W-1:0]      victim_frame,
	output logic [CNT_W-1:0]        tracked_count
);

	localparam int FW = $clog2(FRAMES);

	// stores: contents of link entries matter only while tracked
	logic [FW-1:0] newer_mem [FRAMES];
	logic [FW-1:0] older_mem [FRAMES];
	logic          trk_mem   [FRAMES];

	logic [CNT_W-1:0]   cap_q;
	logic [CNT_W-1:0]   count_q;
	logic [FW-1:0]      newest_q;
	logic [FW-1:0]      oldest_q;
	logic [FW-1:0]      clr_q;

	logic [CMD_W-1:0]   cmd_q;
	logic [FRAME_W-1:0] frame_q;
	logic [FW-1:0]      tgt_q;

	logic [FW-1:0]      newer_rd_q;
	logic [FW-1:0]      older_rd_q;
	logic               trk_rd_q;

	logic               done_q;
	logic [FRAME_W-1:0] victim_q;
	logic [CNT_W-1:0]   tcount_q;

	logic               is_vic, is_pin, is_unpin, in_rng, nonempty;
	logic               do_unlink, do_insert, mid;
	logic               nl_we, ol_we, trk_we;
	logic [FW-1:0]      nl_addr, nl_data, ol_addr, ol_data, trk_addr;
	logic               trk_data;
	logic [FW-1:0]      newest_d, oldest_d;
	logic [CNT_W-1:0]   count_d;

	assign sts.clr_last = (clr_q == FW'(FRAMES - 1));

	assign is_vic   = (cmd_q == CMD_VICTIM);
	assign is_pin   = (cmd_q == CMD_PIN);
	assign is_unpin = (cmd_q == CMD_UNPIN);
	assign in_rng   = (32'(frame_q) < 32'(FRAMES));
	assign nonempty = (count_q != '0);

	assign do_unlink = (is_vic && nonempty) || (is_pin && in_rng && trk_rd_q);
	assign do_insert = is_unpin && in_rng && (count_q < cap_q) && !trk_rd_q;
	// frame sits strictly inside the list
	assign mid = (count_q > CNT_W'(1)) && (tgt_q != oldest_q) && (tgt_q != newest_q);

	always_comb begin
		nl_we    = 1'b0;
		ol_we    = 1'b0;
		nl_addr  = newer_rd_q;
		nl_data  = tgt_q;
		ol_addr  = tgt_q;
		ol_data  = newest_q;
		trk_we   = cmd.clr;
		trk_addr = clr_q;
		trk_data = 1'b0;
		newest_d = newest_q;
		oldest_d = oldest_q;
		count_d  = count_q;
		if (cmd.exec && do_unlink) begin
			trk_we   = 1'b1;
			trk_addr = tgt_q;
			count_d  = count_q - CNT_W'(1);
			priority if (count_q <= CNT_W'(1)) begin
				newest_d = '0;
				oldest_d = '0;
			end else if (tgt_q == oldest_q) begin
				oldest_d = newer_rd_q;
			end else if (tgt_q == newest_q) begin
				newest_d = older_rd_q;
			end else if (mid) begin
				// bridge the neighbours
				nl_we   = 1'b1;
				nl_addr = older_rd_q;
				nl_data = newer_rd_q;
				ol_we   = 1'b1;
				ol_addr = newer_rd_q;
				ol_data = older_rd_q;
			end
		end else if (cmd.exec && do_insert) begin
			trk_we   = 1'b1;
			trk_addr = tgt_q;
			trk_data = 1'b1;
			count_d  = count_q + CNT_W'(1);
			newest_d = tgt_q;
			if (!nonempty) begin
				oldest_d = tgt_q;
			end else begin
				nl_we   = 1'b1;
				nl_addr = newest_q;
				nl_data = tgt_q;
				ol_we   = 1'b1;
				ol_addr = tgt_q;
				ol_data = newest_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (nl_we)
			newer_mem[nl_addr] <= nl_data;
		if (ol_we)
			older_mem[ol_addr] <= ol_data;
		if (trk_we)
			trk_mem[trk_addr] <= trk_data;
		if (cmd.rd) begin
			newer_rd_q <= newer_mem[tgt_q];
			older_rd_q <= older_mem[tgt_q];
			trk_rd_q   <= trk_mem[tgt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= command;
			frame_q <= frame;
			tgt_q   <= (command == CMD_VICTIM) ? oldest_q : FW'(frame);
		end
		if (cmd.exec) begin
			done_q   <= do_unlink || do_insert;
			victim_q <= (is_vic && nonempty) ? FRAME_W'(tgt_q) : '0;
			tcount_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			count_q  <= '0;
			newest_q <= '0;
			oldest_q <= '0;
			clr_q    <= '0;
		end else begin
			if (cfg_we)
				cap_q <= capacity;
			if (cmd.clr)
				clr_q <= clr_q + FW'(1);
			count_q  <= count_d;
			newest_q <= newest_d;
			oldest_q <= oldest_d;
		end
	end

	assign done_res      = done_q;
	assign victim_frame  = victim_q;
	assign tracked_count = tcount_q;

endmodule : lfr_dp
`default_nettype wire

[hdl/lru_frame_replacer_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LRU frame replacer core
// Recency list of evictable frames with victim, pin and unpin requests.
// ---------------------------------------------------------------------------
// Each request is accepted in the idle state, then reads the link and
// tracked stores (registered read), then updates the list and loads the
// result register, which offers the result. The block takes no new request
// until the update of the last one is done. A request is accepted while a
// previous result still waits; its update stalls only if that result has
// not been taken by then. After reset the tracked store is cleared one entry
// a cycle, through all FRAMES entries, before the first request is accepted;
// capacity writes are taken throughout.
// ---------------------------------------------------------------------------
module lru_frame_replacer_core
	import lfr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CNT_W-1:0]   capacity,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CMD_W-1:0]   command,
	input  wire logic [FRAME_W-1:0] frame,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    done_res,
	output logic [FRAME_W-1:0]      victim_frame,
	output logic [CNT_W-1:0]        tracked_count
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	lfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lfr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.capacity      (capacity),
		.command       (command),
		.frame         (frame),
		.done_res      (done_res),
		.victim_frame  (victim_frame),
		.tracked_count (tracked_count)
	);

endmodule : lru_frame_replacer_core
`default_nettype wire

[tb/sv/lru_frame_replacer_core_tb.sv]
// ---------------------------------------------------------------------------
// LRU frame replacer core testbench
// Drives victim, pin and unpin requests through the request and result
// channels, mirrors the recency list in a scoreboard and checks every result
// field against it. Capacity is changed between phases while the block is
// quiet; both channels idle at random, and the result side is held off once
// for a long stretch so that the block fills and stalls its input.
// ---------------------------------------------------------------------------
module lru_frame_replacer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lfr_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int IDLE_PCT       = 9;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 10;
	localparam int MAX_REPORTS    = 10;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	// Scoreboard: private copy of the recency list, plus the results it owes
	class recency_tracker;
		typedef struct {
			logic               done;
			logic [FRAME_W-1:0] victim;
			logic [CNT_W-1:0]   count;
		} outcome_t;

		bit [FRAME_W-1:0] newer_of [FRAMES];
		bit [FRAME_W-1:0] older_of [FRAMES];
		bit               is_tracked [FRAMES];
		bit [FRAME_W-1:0] newest, oldest;
		bit [CNT_W-1:0]   tracked_n;
		bit [CNT_W-1:0]   cap = CAP_RESET;
		outcome_t         owed [$];
		int               faults;
		int               hits [4];
		int               misses [4];

		function void remove_frame(bit [FRAME_W-1:0] f);
			bit [FRAME_W-1:0] a, b;
			if (tracked_n <= 1) begin
				newest = '0;
				oldest = '0;
			end else if (f == oldest) begin
				oldest = newer_of[f];
			end else if (f == newest) begin
				newest = older_of[f];
			end else begin
				a = older_of[f];
				b = newer_of[f];
				newer_of[a] = b;
				older_of[b] = a;
			end
			is_tracked[f] = 1'b0;
			if (tracked_n != 0) tracked_n--;
		endfunction

		function void append_newest(bit [FRAME_W-1:0] f);
			if (tracked_n == 0) begin
				oldest = f;
			end else begin
				newer_of[newest] = f;
				older_of[f] = newest;
			end
			newest = f;
			is_tracked[f] = 1'b1;
			tracked_n++;
		endfunction

		function void take_request(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] f);
			outcome_t o;
			o.done = 1'b0;
			o.victim = '0;
			case (cmd)
			CMD_VICTIM: if (tracked_n != 0) begin
				o.victim = oldest;
				remove_frame(oldest);
				o.done = 1'b1;
			end
			CMD_PIN: if (is_tracked[f]) begin
				remove_frame(f);
				o.done = 1'b1;
			end
			CMD_UNPIN: if (tracked_n < cap && !is_tracked[f]) begin
				append_newest(f);
				o.done = 1'b1;
			end
			CMD_NONE: ;
			endcase
			o.count = tracked_n;
			if (o.done) hits[cmd]++;
			else misses[cmd]++;
			owed.push_back(o);
		endfunction

		function void note_fault(string what);
			faults++;
			if (faults <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
		endfunction

		function void match_result(logic done, logic [FRAME_W-1:0] victim,
				logic [CNT_W-1:0] count);
			outcome_t want;
			if (owed.size() == 0) begin
				note_fault($sformatf("unrequested result done %b victim %0d count %0d",
					done, victim, count));
				return;
			end
			want = owed.pop_front();
			if (want.done !== done || want.victim !== victim || want.count !== count)
				note_fault($sformatf({"expected done %b victim %0d count %0d, ",
					"got done %b victim %0d count %0d"}, want.done, want.victim,
					want.count, done, victim, count));
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function logic [FRAME_W-1:0] any_tracked_frame();
			logic [FRAME_W-1:0] pool [$];
			for (int i = 0; i < FRAMES; i++)
				if (is_tracked[i]) pool.push_back(FRAME_W'(i));
			if (pool.size() == 0) return FRAME_W'($urandom_range(0, FRAMES - 1));
			return pool[$urandom_range(0, pool.size() - 1)];
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CNT_W-1:0]   capacity;
	logic               in_valid;
	logic               in_ready;
	logic [CMD_W-1:0]   command;
	logic [FRAME_W-1:0] frame;
	logic               out_valid;
	logic               out_ready;
	logic               done_res;
	logic [FRAME_W-1:0] victim_frame;
	logic [CNT_W-1:0]   tracked_count;

	recency_tracker book = new();
	bit             steady;
	bit             hold_req;
	int             stall_cycles;
	int             hold_left;
	int             holds_done;
	logic [CNT_W-1:0] odd_cap;

	lru_frame_replacer_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.capacity      (capacity),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.frame         (frame),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.done_res      (done_res),
		.victim_frame  (victim_frame),
		.tracked_count (tracked_count)
	);

	always #CLK_HALF clk = ~clk;

	// Result side: check what was taken, then choose next cycle's ready
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				book.match_result(done_res, victim_frame, tracked_count);
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				holds_done++;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: nothing moved for %0d cycles, %0d results outstanding",
					stall_cycles, book.pending());
				$display("lru_frame_replacer_core_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [CMD_W-1:0] c, input logic [FRAME_W-1:0] f);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		frame <= f;
		do @(posedge clk); while (!in_ready);
		book.take_request(c, f);
	endtask

	// Stop offering and wait until every owed result is back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] v);
		cfg_valid <= 1'b1;
		capacity <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.cap = v;
	endtask

	task automatic run_phase(input int n, input int p_unpin, input int p_pin,
			input int p_victim);
		int               roll;
		logic [CMD_W-1:0] c;
		logic [FRAME_W-1:0] f;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			f = FRAME_W'($urandom_range(0, FRAMES - 1));
			if (roll < p_unpin) begin
				c = CMD_UNPIN;
				// re-offer a tracked frame now and then
				if ($urandom_range(0, 9) == 0) f = book.any_tracked_frame();
			end else if (roll < p_unpin + p_pin) begin
				c = CMD_PIN;
				if ($urandom_range(0, 9) < 7) f = book.any_tracked_frame();
			end else if (roll < p_unpin + p_pin + p_victim) begin
				c = CMD_VICTIM;
			end else begin
				c = CMD_NONE;
			end
			send_request(c, f);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		capacity <= CAP_RESET;
		in_valid <= 1'b0;
		command <= CMD_VICTIM;
		frame <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset capacity, empty set, list ends and middle
		send_request(CMD_VICTIM, 6'd63);
		send_request(CMD_PIN, 6'd0);
		send_request(CMD_NONE, 6'd63);
		send_request(CMD_UNPIN, 6'd0);
		send_request(CMD_UNPIN, 6'd63);
		send_request(CMD_UNPIN, 6'd0);
		send_request(CMD_UNPIN, 6'd21);
		send_request(CMD_UNPIN, 6'd42);
		send_request(CMD_NONE, 6'd42);
		send_request(CMD_PIN, 6'd63);
		send_request(CMD_PIN, 6'd42);
		send_request(CMD_PIN, 6'd42);
		send_request(CMD_UNPIN, 6'd63);
		send_request(CMD_VICTIM, 6'd0);
		send_request(CMD_VICTIM, 6'd0);
		send_request(CMD_VICTIM, 6'd0);
		send_request(CMD_VICTIM, 6'd0);
		settle();
		write_capacity(7'd0);
		send_request(CMD_UNPIN, 6'd5);
		settle();
		write_capacity(7'd2);
		send_request(CMD_UNPIN, 6'd1);
		send_request(CMD_UNPIN, 6'd2);
		send_request(CMD_UNPIN, 6'd3);
		send_request(CMD_PIN, 6'd1);
		send_request(CMD_UNPIN, 6'd3);
		send_request(CMD_VICTIM, 6'd0);
		send_request(CMD_VICTIM, 6'd0);

		// fill towards full capacity with no idling on either side
		settle();
		write_capacity(7'd64);
		steady = 1'b1;
		run_phase(200, 70, 15, 12);
		steady = 1'b0;

		// result side held off while requests keep coming
		settle();
		write_capacity(7'd63);
		hold_req = 1'b1;
		run_phase(150, 50, 25, 22);

		settle();
		write_capacity(7'd0);
		run_phase(40, 50, 25, 22);

		settle();
		write_capacity(7'd1);
		run_phase(60, 45, 25, 27);

		settle();
		write_capacity(7'd5);
		run_phase(50, 55, 20, 22);
		settle();
		run_phase(50, 55, 20, 22);

		// drain-heavy mix at an arbitrary capacity
		settle();
		odd_cap = CNT_W'($urandom_range(2, 64));
		write_capacity(odd_cap);
		run_phase(100, 35, 30, 32);

		settle();
		write_capacity(7'd64);
		run_phase(100, 50, 25, 22);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d requests at capacities 64, 0, 2, 63, 1, 5 and %0d; %0d long hold-off(s)",
			book.hits.sum() + book.misses.sum(), odd_cap, holds_done);
		$display("victims %0d/%0d empty, pins %0d/%0d missed, unpins %0d/%0d refused, %0d no-ops",
			book.hits[CMD_VICTIM], book.misses[CMD_VICTIM], book.hits[CMD_PIN],
			book.misses[CMD_PIN], book.hits[CMD_UNPIN], book.misses[CMD_UNPIN],
			book.misses[CMD_NONE]);
		if (book.faults == 0 && book.pending() == 0)
			$display("lru_frame_replacer_core_tb: PASS");
		else
			$display("lru_frame_replacer_core_tb: FAIL");
		$finish;
	end

endmodule

[files.f]
hdl/lfr_pkg.sv
hdl/lfr_ctrl.sv
hdl/lfr_dp.sv
hdl/lru_frame_replacer_core.sv
tb/sv/lru_frame_replacer_core_tb.sv
